>>> hdl/pixel_format_alpha_writer_macros.svh
// Assertion macros for the pixel format alpha writer.
`ifndef PIXEL_FORMAT_ALPHA_WRITER_MACROS_SVH
`define PIXEL_FORMAT_ALPHA_WRITER_MACROS_SVH

`ifndef ASSERT_OFF

`define PFAW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PFAW_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`else

`define PFAW_ASSERT(label, prop, msg)

`define PFAW_ASSERT_IMPL(label, pre, post, msg)

`endif

`endif

>>> hdl/pfaw_pkg.sv
// Types and codes for the pixel format alpha writer.
package pfaw_pkg;

  typedef enum logic [1:0] {
    FMT_RGB555  = 2'd0,
    FMT_RGB565  = 2'd1,
    FMT_BGR24   = 2'd2,
    FMT_XRGB32  = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_TEST  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_t;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_MODE   = 1'b1;

  localparam fmt_t  FORMAT_RESET = FMT_RGB565;
  localparam logic [1:0] MODE_RESET = 2'd0;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] dest_pixel;
  } request_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        write_enable;
  } result_t;

endpackage

>>> hdl/pixel_format_alpha_writer.sv
// Pixel format alpha writer: pack, alpha test or blend one pixel per clock.
// An accepted request passes the input register, then the result and done registers.
// Throughput: one request per cycle, set by the input register and result register pair.
// busy is high only during reset; the receiver cannot stall, so done is never held off.
// Reset (rst, synchronous, active high) sets pixel_format to 16-bit 565, write_mode to
// plain write, and drops any request in flight.
`include "pixel_format_alpha_writer_macros.svh"

module pixel_format_alpha_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pfaw_pkg::request_t request,
  output logic               done,
  output pfaw_pkg::result_t  result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data
);

  pfaw_pkg::fmt_t     pixel_format;
  logic [1:0]         write_mode;
  logic               stage_valid;
  pfaw_pkg::request_t stage_req;
  pfaw_pkg::result_t  result_next;

  logic [7:0]  dr, dg, db;
  logic [7:0]  nr, ng, nb;
  logic [7:0]  plain_top;

  function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                     input logic [7:0] a);
    logic [15:0] ps;
    logic [15:0] pd;
    logic [8:0]  sum;
    ps  = 16'(s) * 16'(a);
    pd  = 16'(d) * 16'(8'hFF - a);
    sum = {1'b0, ps[15:8]} + {1'b0, pd[15:8]};
    return sum[7:0];
  endfunction

  function automatic logic [31:0] pack(input pfaw_pkg::fmt_t f, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       input logic [7:0] top);
    logic [31:0] w;
    unique case (f)
      pfaw_pkg::FMT_RGB555: w = {17'b0, r[7:3], g[7:3], b[7:3]};
      pfaw_pkg::FMT_RGB565: w = {16'b0, r[7:3], g[7:2], b[7:3]};
      default:              w = {top, r, g, b};
    endcase
    return w;
  endfunction

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= pfaw_pkg::FORMAT_RESET;
      write_mode   <= pfaw_pkg::MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfaw_pkg::REG_FORMAT: pixel_format <= pfaw_pkg::fmt_t'(cfg_data);
        pfaw_pkg::REG_MODE:   write_mode   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
      done        <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_req <= request;
    result    <= result_next;
  end

  always_comb begin
    unique case (pixel_format)
      pfaw_pkg::FMT_RGB555: begin
        dr = {stage_req.dest_pixel[14:10], 3'b0};
        dg = {stage_req.dest_pixel[9:5], 3'b0};
        db = {stage_req.dest_pixel[4:0], 3'b0};
      end
      pfaw_pkg::FMT_RGB565: begin
        dr = {stage_req.dest_pixel[15:11], 3'b0};
        dg = {stage_req.dest_pixel[10:5], 2'b0};
        db = {stage_req.dest_pixel[4:0], 3'b0};
      end
      default: begin
        dr = stage_req.dest_pixel[23:16];
        dg = stage_req.dest_pixel[15:8];
        db = stage_req.dest_pixel[7:0];
      end
    endcase

    nr = mix(stage_req.red,   dr, stage_req.alpha);
    ng = mix(stage_req.green, dg, stage_req.alpha);
    nb = mix(stage_req.blue,  db, stage_req.alpha);

    plain_top = (pixel_format == pfaw_pkg::FMT_BGR24) ? stage_req.dest_pixel[31:24] : 8'h00;

    priority if (write_mode == pfaw_pkg::MODE_BLEND) begin
      result_next.pixel_out    = pack(pixel_format, nr, ng, nb, stage_req.dest_pixel[31:24]);
      result_next.write_enable = 1'b1;
    end else if (write_mode == pfaw_pkg::MODE_TEST && stage_req.alpha == 8'h00) begin
      result_next.pixel_out    = stage_req.dest_pixel;
      result_next.write_enable = 1'b0;
    end else begin
      result_next.pixel_out    = pack(pixel_format, stage_req.red, stage_req.green,
                                      stage_req.blue, plain_top);
      result_next.write_enable = 1'b1;
    end
  end

  `PFAW_ASSERT_IMPL(a_done_follows_start, start && !busy, ##2 done, "result lost")
  `PFAW_ASSERT_IMPL(a_done_has_start, done, $past(start && !busy, 2), "result invented")
  `PFAW_ASSERT_IMPL(a_reject_only_test, done && !result.write_enable,
                    write_mode == pfaw_pkg::MODE_TEST, "write suppressed outside alpha test")
  `PFAW_ASSERT_IMPL(a_narrow_upper_zero,
                    done && result.write_enable &&
                    (pixel_format == pfaw_pkg::FMT_RGB555 || pixel_format == pfaw_pkg::FMT_RGB565),
                    result.pixel_out[31:16] == 16'h0000, "upper bits set in 16-bit format")

endmodule
